[hw/rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Token kinds, character codes, shared types and the character class helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	// Default width of the internal byte position counter.
	localparam int POSITION_BITS = 16;

	// Number of token bundles buffered between scanner and output stage.
	localparam int QUEUE_DEPTH = 4;

	// Most tokens that one input item can cause.
	localparam int MAX_TOKENS = 3;

	// Token kinds.
	localparam logic [3:0] K_END     = 4'd0;
	localparam logic [3:0] K_NUM     = 4'd1;
	localparam logic [3:0] K_STR     = 4'd2;
	localparam logic [3:0] K_IDENT   = 4'd3;
	localparam logic [3:0] K_DISPLAY = 4'd4;
	localparam logic [3:0] K_LPAREN  = 4'd5;
	localparam logic [3:0] K_RPAREN  = 4'd6;
	localparam logic [3:0] K_SEMI    = 4'd7;
	localparam logic [3:0] K_COMMA   = 4'd8;

	// Character codes the scanner reacts to.
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// Length of the keyword "display".
	localparam logic [2:0] KW_LEN = 3'd7;

	// One token as it leaves the block.
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
	} tok_t;

	// All tokens caused by one input item, in order.
	typedef struct packed {
		logic [1:0]                 count;
		tok_t [MAX_TOKENS-1:0]      tok;
	} bundle_t;

	// Queue status seen by scanner and output stage.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(c == CH_UNDER);
	endfunction

	// Characters of "display" by index.
	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h64;
			3'd1: r = 8'h69;
			3'd2: r = 8'h73;
			3'd3: r = 8'h70;
			3'd4: r = 8'h6C;
			3'd5: r = 8'h61;
			3'd6: r = 8'h79;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/stt_front.sv]
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Accepts source bytes, tracks the scan mode and builds the bundle of tokens
// that each byte and each end of text causes.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front #(
	parameter int POSITION_BITS = stt_pkg::POSITION_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             src_valid,
	output logic                  src_stall,
	input  wire logic [7:0]       ch,
	input  wire logic             has_char,
	input  wire logic             end_of_text,
	input  wire stt_pkg::q_stat_t q_stat,
	output logic                  push,
	output stt_pkg::bundle_t      bundle
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	// Scan modes.
	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_INT   = 3'd1;
	localparam logic [2:0] MODE_DOT   = 3'd2;
	localparam logic [2:0] MODE_FRAC  = 3'd3;
	localparam logic [2:0] MODE_IDENT = 3'd4;
	localparam logic [2:0] MODE_STR   = 3'd5;
	localparam logic [2:0] MODE_ESC   = 3'd6;

	logic [2:0]               mode_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] origin_q;
	logic [7:0]               quote_q;
	logic [2:0]               kwp_q;
	logic                     kwa_q;

	logic [2:0]               mode_d;
	logic [POSITION_BITS-1:0] pos_d;
	logic [POSITION_BITS-1:0] origin_d;
	logic [7:0]               quote_d;
	logic [2:0]               kwp_d;
	logic                     kwa_d;

	stt_pkg::tok_t            cand [4];
	logic [3:0]               cand_v;
	logic                     accept;

	// Distance from one position to another less an optional one (a quote or a dot), floored at zero.
	function automatic logic [15:0] span(input logic [POSITION_BITS-1:0] from,
			input logic [POSITION_BITS-1:0] to, input logic less);
		logic [POSITION_BITS-1:0] diff;
		logic [POSITION_BITS-1:0] r;
		diff = to - from;
		if ((to < from) || (diff < POSITION_BITS'(less)))
			r = '0;
		else
			r = diff - POSITION_BITS'(less);
		return 16'(r);
	endfunction

	function automatic stt_pkg::tok_t mk_tok(input logic [3:0] kind,
			input logic [POSITION_BITS-1:0] start, input logic [15:0] len);
		stt_pkg::tok_t t;
		t.kind   = kind;
		t.start  = 16'(start);
		t.length = len;
		return t;
	endfunction

	// The scanner takes an item whenever the queue has a free bundle slot.
	assign src_stall = q_stat.full;
	assign accept    = src_valid && !src_stall;

	// Next state and the candidate tokens: a token closed by the byte, a
	// punctuator, a token closed by the end of text and the end token.
	always_comb begin
		logic [POSITION_BITS-1:0] pos1;
		logic                     again;
		mode_d   = mode_q;
		pos_d    = pos_q;
		origin_d = origin_q;
		quote_d  = quote_q;
		kwp_d    = kwp_q;
		kwa_d    = kwa_q;
		again    = 1'b0;
		pos1     = pos_q;
		cand_v   = '0;
		for (int i = 0; i < 4; i++) begin
			cand[i] = '0;
		end

		if (has_char) begin
			unique case (mode_q)
				MODE_INT: begin
					if (ch == stt_pkg::CH_DOT) begin
						mode_d = MODE_DOT;
					end else if (!stt_pkg::is_digit(ch)) begin
						cand_v[0] = 1'b1;
						cand[0]   = mk_tok(stt_pkg::K_NUM, origin_q, span(origin_q, pos_q, 1'b0));
						again     = 1'b1;
					end
				end
				MODE_DOT: begin
					if (stt_pkg::is_digit(ch)) begin
						mode_d = MODE_FRAC;
					end else begin
						cand_v[0] = 1'b1;
						cand[0]   = mk_tok(stt_pkg::K_NUM, origin_q, span(origin_q, pos_q, 1'b1));
						again     = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (!stt_pkg::is_digit(ch)) begin
						cand_v[0] = 1'b1;
						cand[0]   = mk_tok(stt_pkg::K_NUM, origin_q, span(origin_q, pos_q, 1'b0));
						again     = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (stt_pkg::is_alpha(ch) || stt_pkg::is_digit(ch)) begin
						if (kwa_q && (kwp_q < stt_pkg::KW_LEN) && (ch == stt_pkg::kw_char(kwp_q)))
							kwp_d = kwp_q + 3'd1;
						else
							kwa_d = 1'b0;
					end else begin
						cand_v[0] = 1'b1;
						cand[0]   = mk_tok((kwa_q && (kwp_q == stt_pkg::KW_LEN)) ?
							stt_pkg::K_DISPLAY : stt_pkg::K_IDENT,
							origin_q, span(origin_q, pos_q, 1'b0));
						again     = 1'b1;
					end
				end
				MODE_STR: begin
					if (ch == stt_pkg::CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else if (ch == quote_q) begin
						cand_v[0] = 1'b1;
						cand[0]   = mk_tok(stt_pkg::K_STR,
							(origin_q < POS_MAX) ? origin_q + 1'b1 : POS_MAX,
							span(origin_q, pos_q, 1'b1));
						mode_d    = MODE_IDLE;
					end
				end
				MODE_ESC: begin
					mode_d = MODE_STR;
				end
				default: begin
					again = 1'b1;
				end
			endcase

			// The byte starts over in idle when it ended a number or identifier or none was open.
			if (again) begin
				mode_d = MODE_IDLE;
				unique case (ch) inside
					stt_pkg::CH_LPAREN: begin
						cand_v[1] = 1'b1;
						cand[1]   = mk_tok(stt_pkg::K_LPAREN, pos_q, 16'd1);
					end
					stt_pkg::CH_RPAREN: begin
						cand_v[1] = 1'b1;
						cand[1]   = mk_tok(stt_pkg::K_RPAREN, pos_q, 16'd1);
					end
					stt_pkg::CH_SEMI: begin
						cand_v[1] = 1'b1;
						cand[1]   = mk_tok(stt_pkg::K_SEMI, pos_q, 16'd1);
					end
					stt_pkg::CH_COMMA: begin
						cand_v[1] = 1'b1;
						cand[1]   = mk_tok(stt_pkg::K_COMMA, pos_q, 16'd1);
					end
					stt_pkg::CH_SQUOTE, stt_pkg::CH_DQUOTE: begin
						mode_d   = MODE_STR;
						origin_d = pos_q;
						quote_d  = ch;
					end
					default: begin
						if (stt_pkg::is_digit(ch)) begin
							mode_d   = MODE_INT;
							origin_d = pos_q;
						end else if (stt_pkg::is_alpha(ch)) begin
							mode_d   = MODE_IDENT;
							origin_d = pos_q;
							kwp_d    = 3'd1;
							kwa_d    = (ch == stt_pkg::kw_char(3'd0));
						end
					end
				endcase
			end

			pos1  = (pos_q < POS_MAX) ? pos_q + 1'b1 : POS_MAX;
			pos_d = pos1;
		end

		// End of text closes the open token, adds the end token and restarts.
		if (end_of_text) begin
			unique case (mode_d)
				MODE_INT, MODE_FRAC: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk_tok(stt_pkg::K_NUM, origin_d, span(origin_d, pos1, 1'b0));
				end
				MODE_DOT: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk_tok(stt_pkg::K_NUM, origin_d, span(origin_d, pos1, 1'b1));
				end
				MODE_IDENT: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk_tok((kwa_d && (kwp_d == stt_pkg::KW_LEN)) ?
						stt_pkg::K_DISPLAY : stt_pkg::K_IDENT,
						origin_d, span(origin_d, pos1, 1'b0));
				end
				MODE_STR, MODE_ESC: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk_tok(stt_pkg::K_STR,
						(origin_d < POS_MAX) ? origin_d + 1'b1 : POS_MAX,
						span(origin_d, pos1, 1'b1));
				end
				default: begin
				end
			endcase
			cand_v[3] = 1'b1;
			cand[3]   = mk_tok(stt_pkg::K_END, pos1, 16'd0);
			mode_d    = MODE_IDLE;
			pos_d     = '0;
			origin_d  = '0;
			quote_d   = '0;
			kwp_d     = '0;
			kwa_d     = 1'b0;
		end
	end

	// Pack the present candidates into consecutive bundle slots.
	always_comb begin
		logic [1:0] cnt;
		cnt    = '0;
		bundle = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i] && (cnt != 2'd3)) begin
				bundle.tok[cnt] = cand[i];
				cnt             = cnt + 2'd1;
			end
		end
		bundle.count = cnt;
	end

	assign push = accept && (bundle.count != 2'd0);

	// Scanner state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			origin_q <= '0;
			quote_q  <= '0;
			kwp_q    <= '0;
			kwa_q    <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			origin_q <= origin_d;
			quote_q  <= quote_d;
			kwp_q    <= kwp_d;
			kwa_q    <= kwa_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/stt_queue.sv]
// ----------------------------------------------------------------------------
// Tokenizer bundle queue
// Short first-in first-out buffer of token bundles between scanner and output.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue #(
	parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire stt_pkg::bundle_t wr_bundle,
	input  wire logic             pop,
	output stt_pkg::bundle_t      head,
	output stt_pkg::q_stat_t      q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	stt_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// Bundle storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_bundle;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/stt_back.sv]
// ----------------------------------------------------------------------------
// Tokenizer output stage
// Hands out the tokens of each bundle one per transfer through an output
// register and marks the last token of every bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stt_pkg::bundle_t head,
	input  wire stt_pkg::q_stat_t q_stat,
	output logic                  pop,
	output logic                  tok_valid,
	input  wire logic             tok_stall,
	output logic [3:0]            token_kind,
	output logic [15:0]           token_start,
	output logic [15:0]           token_length,
	output logic                  last_of_run
);

	logic          out_valid_q;
	logic [1:0]    idx_q;
	logic          load;
	logic          is_last;
	stt_pkg::tok_t sel;

	// The output register refills when empty or when its token transfers.
	assign load    = !q_stat.empty && (!out_valid_q || !tok_stall);
	assign sel     = head.tok[idx_q];
	assign is_last = (idx_q == head.count - 2'd1);
	assign pop     = load && is_last;

	assign tok_valid = out_valid_q;

	// Position within the current bundle and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!tok_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			token_kind   <= sel.kind;
			token_start  <= sel.start;
			token_length <= sel.length;
			last_of_run  <= is_last;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer: source bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
// Usage:
//   The source channel (src_valid/src_stall) takes one item per transfer: a
//   byte in ch when has_char is set, and end_of_text to close the text. The
//   token channel (tok_valid/tok_stall) gives one token per transfer, with
//   last_of_run set on the final token caused by an input item.
//   The first token of an item is registered: the transfer edge writes its
//   bundle into the queue, and at the earliest the next edge loads the
//   output register.
//   Throughput: one item per cycle while tok_stall stays low and each item
//   causes at most one token; the output register hands out one token per
//   cycle when not stalled, so an item that causes two or three tokens takes
//   one transfer per token. A four-bundle queue separates scanner and output register.
//   When the receiver stalls, the output token holds, the queue fills, and
//   src_stall rises once the queue is full.
//   Reset clears the scan state, the byte position, the queue and the output
//   register; the first byte after reset or after an end of text is position 0.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
	parameter int POSITION_BITS = stt_pkg::POSITION_BITS,
	parameter int QUEUE_DEPTH   = stt_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        has_char,
	input  wire logic        end_of_text,
	output logic             tok_valid,
	input  wire logic        tok_stall,
	output logic [3:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic             last_of_run
);

	stt_pkg::q_stat_t q_stat;
	stt_pkg::bundle_t wr_bundle;
	stt_pkg::bundle_t head;
	logic             push;
	logic             pop;

	// Scanner.
	stt_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.ch          (ch),
		.has_char    (has_char),
		.end_of_text (end_of_text),
		.q_stat      (q_stat),
		.push        (push),
		.bundle      (wr_bundle)
	);

	// Bundle queue.
	stt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_bundle (wr_bundle),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// Output stage.
	stt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	// The end token is always the final token of its item and has no length.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind == stt_pkg::K_END) |-> last_of_run && (token_length == 16'd0))
		else $error("end token without last_of_run or with nonzero length");

	// A bundle is never written into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("bundle pushed into full queue");

	// A bundle in the queue carries at least one token.
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> (head.count != 2'd0))
		else $error("empty bundle at queue head");

	// The output register never stays empty while the queue holds tokens.
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_valid && !q_stat.empty |=> tok_valid)
		else $error("output register not refilled from queue");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Feeds directed and random source texts through the tokenizer, predicts the
// token stream with a behavioral lexer and compares every token transfer.
// ----------------------------------------------------------------------------

module testbench;

	// Cycles without any transfer before the run is abandoned.
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 270;
	localparam int WIND_DOWN = 40;
	localparam logic [15:0] POS_TOP = 16'hFFFF;
	localparam logic [55:0] KEYWORD = "display";

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_IDENT, SCAN_STR, SCAN_ESC
	} scan_t;

	typedef struct packed {
		logic [7:0] code;
		logic       has_byte;
		logic       closes;
	} src_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	logic [7:0] ch = 8'd0;
	logic has_char = 1'b0;
	logic end_of_text = 1'b0;
	logic tok_valid;
	logic tok_stall = 1'b0;
	logic [3:0] token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic last_of_run;

	src_item_t source_items[$];
	token_t lexed_tokens[$];
	token_t run_tokens[$];
	int total_items = 0;
	int items_accepted = 0;
	int token_errors = 0;
	int idle_cycles = 0;
	int src_gap = 0;
	int src_calm = 0;
	int stall_gap = 0;
	int stall_calm = 0;

	// Lexer state of the prediction.
	scan_t lex_mode = SCAN_IDLE;
	logic [15:0] lex_pos = 16'd0;
	logic [15:0] lex_origin = 16'd0;
	logic [7:0] lex_quote = 8'd0;
	logic [2:0] kw_count = 3'd0;
	logic kw_match = 1'b0;

	source_text_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.ch(ch),
		.has_char(has_char),
		.end_of_text(end_of_text),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.token_kind(token_kind),
		.token_start(token_start),
		.token_length(token_length),
		.last_of_run(last_of_run)
	);

	always #10 clk = ~clk;

	// Character classes and keyword bytes.
	function automatic logic is_num(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(c == stt_pkg::CH_UNDER);
	endfunction

	function automatic logic [7:0] kw_byte(input logic [2:0] idx);
		return KEYWORD[8 * (6 - int'(idx)) +: 8];
	endfunction

	// Distance between two positions less an offset, floored at zero.
	function automatic logic [15:0] span_len(input logic [15:0] from, input logic [15:0] upto,
		input logic [15:0] less);
		if (upto < from || upto - from < less)
			return 16'd0;
		return upto - from - less;
	endfunction

	function automatic void add_token(input logic [3:0] k, input logic [15:0] s,
		input logic [15:0] l);
		run_tokens.push_back('{k, s, l, 1'b0});
	endfunction

	function automatic void close_ident(input logic [15:0] p);
		add_token((kw_match && kw_count == stt_pkg::KW_LEN) ? stt_pkg::K_DISPLAY :
			stt_pkg::K_IDENT, lex_origin, span_len(lex_origin, p, 16'd0));
	endfunction

	function automatic void close_string(input logic [15:0] p);
		add_token(stt_pkg::K_STR, (lex_origin < POS_TOP) ? lex_origin + 16'd1 : POS_TOP,
			span_len(lex_origin, p, 16'd1));
	endfunction

	// A byte seen between tokens: punctuators finish at once, quotes, digits and letters open a token.
	function automatic void start_from_idle(input logic [7:0] c, input logic [15:0] p);
		lex_mode = SCAN_IDLE;
		case (c)
			stt_pkg::CH_LPAREN: add_token(stt_pkg::K_LPAREN, p, 16'd1);
			stt_pkg::CH_RPAREN: add_token(stt_pkg::K_RPAREN, p, 16'd1);
			stt_pkg::CH_SEMI: add_token(stt_pkg::K_SEMI, p, 16'd1);
			stt_pkg::CH_COMMA: add_token(stt_pkg::K_COMMA, p, 16'd1);
			stt_pkg::CH_SQUOTE, stt_pkg::CH_DQUOTE: begin
				lex_mode = SCAN_STR;
				lex_origin = p;
				lex_quote = c;
			end
			default: begin
				if (is_num(c)) begin
					lex_mode = SCAN_INT;
					lex_origin = p;
				end else if (is_word(c)) begin
					lex_mode = SCAN_IDENT;
					lex_origin = p;
					kw_count = 3'd1;
					kw_match = (c == kw_byte(3'd0));
				end
			end
		endcase
	endfunction

	// Advances the lexer by one source item and queues the tokens it completes.
	task automatic lex_item(input logic [7:0] c, input logic hc, input logic eot);
		logic [15:0] p;
		logic rescan;
		token_t t;
		run_tokens.delete();
		rescan = 1'b0;
		p = lex_pos;
		if (hc) begin
			case (lex_mode)
				SCAN_INT: begin
					if (c == stt_pkg::CH_DOT)
						lex_mode = SCAN_DOT;
					else if (!is_num(c)) begin
						add_token(stt_pkg::K_NUM, lex_origin, span_len(lex_origin, p, 16'd0));
						rescan = 1'b1;
					end
				end
				SCAN_DOT: begin
					if (is_num(c))
						lex_mode = SCAN_FRAC;
					else begin
						// The dot was not part of the number.
						add_token(stt_pkg::K_NUM, lex_origin, span_len(lex_origin, p, 16'd1));
						rescan = 1'b1;
					end
				end
				SCAN_FRAC: begin
					if (!is_num(c)) begin
						add_token(stt_pkg::K_NUM, lex_origin, span_len(lex_origin, p, 16'd0));
						rescan = 1'b1;
					end
				end
				SCAN_IDENT: begin
					if (is_word(c) || is_num(c)) begin
						if (kw_match && kw_count < stt_pkg::KW_LEN && c == kw_byte(kw_count))
							kw_count = kw_count + 3'd1;
						else
							kw_match = 1'b0;
					end else begin
						close_ident(p);
						rescan = 1'b1;
					end
				end
				SCAN_STR: begin
					if (c == stt_pkg::CH_BSLASH)
						lex_mode = SCAN_ESC;
					else if (c == lex_quote) begin
						close_string(p);
						lex_mode = SCAN_IDLE;
					end
				end
				SCAN_ESC: lex_mode = SCAN_STR;
				default: rescan = 1'b1;
			endcase
			if (rescan)
				start_from_idle(c, p);
			lex_pos = (p < POS_TOP) ? p + 16'd1 : POS_TOP;
		end
		// End of text flushes the pending token, adds the end token and restarts.
		if (eot) begin
			p = lex_pos;
			case (lex_mode)
				SCAN_INT, SCAN_FRAC:
					add_token(stt_pkg::K_NUM, lex_origin, span_len(lex_origin, p, 16'd0));
				SCAN_DOT:
					add_token(stt_pkg::K_NUM, lex_origin, span_len(lex_origin, p, 16'd1));
				SCAN_IDENT: close_ident(p);
				SCAN_STR, SCAN_ESC: close_string(p);
				default: ;
			endcase
			add_token(stt_pkg::K_END, p, 16'd0);
			lex_mode = SCAN_IDLE;
			lex_pos = 16'd0;
			lex_origin = 16'd0;
			lex_quote = 8'd0;
			kw_count = 3'd0;
			kw_match = 1'b0;
		end
		if (run_tokens.size() > 0) begin
			t = run_tokens.pop_back();
			t.last = 1'b1;
			run_tokens.push_back(t);
		end
		foreach (run_tokens[i])
			lexed_tokens.push_back(run_tokens[i]);
	endtask

	task automatic flag_error(input string msg);
		token_errors++;
		if (token_errors <= 10)
			$display("%s", msg);
	endtask

	// Stimulus builders.
	task automatic add_item(input logic [7:0] c, input logic hc, input logic eot);
		source_items.push_back('{c, hc, eot});
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], 1'b1, 1'b0);
	endtask

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// One random text: mostly well-formed tokens with noise, then an end item.
	task automatic add_random_text();
		string alpha;
		string punct;
		string blank;
		string words[9];
		int n_tok;
		int n;
		logic [7:0] q;
		logic [7:0] b;
		alpha = "abcdlpsyxzABDXYZ_";
		punct = "();,";
		blank = " \t\r\n";
		words = '{"display", "displa", "displayx", "Display", "d", "dis_play", "x9", "_",
			"display1"};
		n_tok = $urandom_range(1, 10);
		for (int i = 0; i < n_tok; i++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(1, 4);
					for (int k = 0; k < n; k++)
						add_item(8'h30 + 8'($urandom_range(0, 9)), 1'b1, 1'b0);
					if ($urandom_range(0, 2) == 0) begin
						add_item(stt_pkg::CH_DOT, 1'b1, 1'b0);
						n = $urandom_range(0, 3);
						for (int k = 0; k < n; k++)
							add_item(8'h30 + 8'($urandom_range(0, 9)), 1'b1, 1'b0);
					end
				end
				2: add_text(words[$urandom_range(0, 8)]);
				3: begin
					n = $urandom_range(1, 6);
					add_item(pick(alpha), 1'b1, 1'b0);
					for (int k = 1; k < n; k++)
						add_item($urandom_range(0, 3) == 0 ? 8'h30 + 8'($urandom_range(0, 9))
							: pick(alpha), 1'b1, 1'b0);
				end
				4: begin
					q = $urandom_range(0, 1) ? stt_pkg::CH_DQUOTE : stt_pkg::CH_SQUOTE;
					add_item(q, 1'b1, 1'b0);
					n = $urandom_range(0, 5);
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(0, 3) == 0)
							add_item(stt_pkg::CH_BSLASH, 1'b1, 1'b0);
						b = 8'($urandom_range(0, 255));
						add_item(b, 1'b1, 1'b0);
					end
					if ($urandom_range(0, 7) != 0)
						add_item(q, 1'b1, 1'b0);
				end
				5, 6: add_item(pick(punct), 1'b1, 1'b0);
				7: add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				default: begin
					n = $urandom_range(1, 2);
					for (int k = 0; k < n; k++)
						add_item(pick(blank), 1'b1, 1'b0);
				end
			endcase
			if ($urandom_range(0, 15) == 0)
				add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end
		case ($urandom_range(0, 2))
			0: add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			1: add_item(pick(punct), 1'b1, 1'b1);
			default: add_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		endcase
	endtask

	// Source driver: presents queued items and inserts random gaps between them.
	always @(posedge clk) begin
		src_item_t nxt;
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				lex_item(ch, has_char, end_of_text);
				items_accepted++;
			end
			if (!src_valid || !src_stall) begin
				if (src_gap > 0) begin
					src_gap--;
					src_valid <= 1'b0;
				end else if (source_items.size() == 0) begin
					src_valid <= 1'b0;
				end else if (source_items.size() >= WIND_DOWN && src_calm == 0 &&
					$urandom_range(0, 4) == 0) begin
					src_gap = $urandom_range(1, 9) - 1;
					src_calm = $urandom_range(1, 40);
					src_valid <= 1'b0;
				end else begin
					nxt = source_items.pop_front();
					ch <= nxt.code;
					has_char <= nxt.has_byte;
					end_of_text <= nxt.closes;
					src_valid <= 1'b1;
					if (src_calm > 0)
						src_calm--;
				end
			end
		end
	end

	// Token monitor: checks each transfer and drives random stall bursts.
	always @(posedge clk) begin
		token_t want;
		if (arst_n) begin
			if (tok_valid && !tok_stall) begin
				if (lexed_tokens.size() == 0) begin
					flag_error($sformatf("unexpected token: kind %0d start %0d length %0d last %0b",
						token_kind, token_start, token_length, last_of_run));
				end else begin
					want = lexed_tokens.pop_front();
					if (token_kind !== want.kind || token_start !== want.start ||
						token_length !== want.length || last_of_run !== want.last)
						flag_error($sformatf({"token mismatch: expected kind %0d start %0d ",
							"length %0d last %0b, got kind %0d start %0d length %0d last %0b"},
							want.kind, want.start, want.length, want.last, token_kind,
							token_start, token_length, last_of_run));
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				tok_stall <= 1'b1;
			end else if (source_items.size() >= WIND_DOWN && stall_calm == 0 &&
				$urandom_range(0, 4) == 0) begin
				stall_gap = $urandom_range(1, 9) - 1;
				stall_calm = $urandom_range(1, 40);
				tok_stall <= 1'b1;
			end else begin
				tok_stall <= 1'b0;
				if (stall_calm > 0)
					stall_calm--;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		// Keyword, every punctuator, a fraction and an escape inside a string.
		add_text("display(1.5,\"a\\\"\");");
		// An empty item, then NUL and a high byte outside any token.
		add_item(8'hA5, 1'b0, 1'b0);
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b0);
		// Dangling dot followed by a letter that also ends the text.
		add_text("7.");
		add_item("x", 1'b1, 1'b1);
		// Dangling dot closed by a bare end.
		add_text("9.");
		add_item(8'h00, 1'b0, 1'b1);
		// Unterminated string with a trailing backslash.
		add_text("'q\\");
		add_item(8'hFF, 1'b0, 1'b1);

		// Escaped quote inside a string, a fraction and an unterminated string.
		add_text("ab'c\\'d'9.5 x'");
		add_item(8'h00, 1'b0, 1'b1);

		// Random texts fill the run until it holds at least its item count.
		while (source_items.size() < RANDOM_ITEMS)
			add_random_text();
		total_items = source_items.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (items_accepted < total_items || lexed_tokens.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (token_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
